// ----- src/differential_drive_odometry_defines.svh -----
// assertion macros for the odometry block
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_DEFINES_SVH
// property that must hold at every edge outside reset
`define DDO_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// implication over the next cycle
`define DDO_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- src/ddo_pkg.sv -----
// types and constants for the odometry block
package ddo_pkg;
    localparam logic signed [31:0] PI_Q      = 32'sd52707179;
    localparam logic signed [31:0] TWO_PI_Q  = 32'sd105414357;
    localparam logic signed [31:0] HALF_PI_Q = 32'sd26353589;
    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
    localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] SAT_MIN = 32'sh80000000;
    // lowest angle of the reduced range, one LSB above one full turn below pi
    localparam logic signed [31:0] RED_LO = PI_Q - TWO_PI_Q + 32'sd1;

    localparam logic [2:0] REG_LEFT_MM  = 3'd0;
    localparam logic [2:0] REG_RIGHT_MM = 3'd1;
    localparam logic [2:0] REG_INV_WB   = 3'd2;
    localparam logic [2:0] REG_RATE     = 3'd3;
    localparam logic [2:0] REG_ALPHA    = 3'd4;
    localparam logic [2:0] REG_WRAP     = 3'd5;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] left_count;
        logic signed [31:0] right_count;
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic signed [31:0] pose_heading;
    } t_cmd;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] heading;
        logic signed [15:0] turn_count;
        logic signed [31:0] left_speed;
        logic signed [31:0] right_speed;
    } t_pose;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DL, ST_DR, ST_LRAW, ST_RRAW, ST_LFILT, ST_RFILT, ST_DANG,
        ST_HEAD, ST_FOLD, ST_MEAN, ST_RED, ST_ITER, ST_XMUL, ST_YMUL, ST_DONE, ST_OUT
    } t_state;

    function automatic logic [31:0] atan_q(input logic [4:0] i);
        case (i)
            5'd0: atan_q = 32'd13176795;
            5'd1: atan_q = 32'd7778716;
            5'd2: atan_q = 32'd4110060;
            5'd3: atan_q = 32'd2086331;
            5'd4: atan_q = 32'd1047214;
            5'd5: atan_q = 32'd524117;
            5'd6: atan_q = 32'd262123;
            5'd7: atan_q = 32'd131069;
            default: atan_q = (i <= 5'd24) ? (32'd1 << (5'd24 - i)) : 32'd0;
        endcase
    endfunction

    function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
        if (v > 64'sh7fffffff) sat64 = SAT_MAX;
        else if (v < -64'sh80000000) sat64 = SAT_MIN;
        else sat64 = v[31:0];
    endfunction
endpackage

// ----- src/ddo_stream_if.sv -----
// valid/ready channel carrying one payload
interface ddo_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- src/ddo_mul.sv -----
// shared signed 33x33 multiply with rounded right shift, registered output
module ddo_mul (
    input  logic               i_clk,
    input  logic signed [32:0] i_a,
    input  logic signed [32:0] i_b,
    input  logic        [4:0]  i_shift,
    output logic signed [63:0] o_p
);
    logic signed [65:0] w_p;
    logic signed [65:0] w_r;
    always_comb begin
        w_p = i_a * i_b;
        w_r = (i_shift == 5'd0) ? w_p : ((w_p + (66'sd1 <<< (i_shift - 5'd1))) >>> i_shift);
    end
    always_ff @(posedge i_clk) begin
        o_p <= w_r[63:0];
    end
endmodule

// ----- src/differential_drive_odometry.sv -----
// Wheel odometry. An update runs ten sequencer steps that share one multiplier, five steps
// that reduce the mean angle into one turn, CORDIC_STEPS rotation steps, three more multiply
// steps, then the result state and back to idle. A set-pose item goes from idle through the
// fold step straight to the result state. A new item is taken only once the last result beat
// is taken: ready is low while an item is in work and while a result beat waits.
module differential_drive_odometry #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    ddo_stream_if.sink   in_if,
    ddo_stream_if.source out_if
);
    import ddo_pkg::*;
    `include "differential_drive_odometry_defines.svh"

    localparam int SW = $clog2(CORDIC_STEPS + 1);

    logic [23:0] r_lmm, r_rmm, r_iwb;
    logic [13:0] r_rate;
    logic [16:0] r_alpha;
    logic        r_wrap;
    logic signed [31:0] r_llast, r_rlast, r_prev, r_x, r_y, r_h, r_ls, r_rs;
    logic signed [15:0] r_turns;
    logic signed [31:0] r_dl, r_dr, r_lc, r_rc, r_lraw, r_rraw, r_mean;
    logic signed [31:0] r_cx, r_cy, r_cz;
    logic        r_flip;
    logic        r_setpose;
    logic [SW-1:0] r_it;
    t_state r_st, n_st;

    logic signed [32:0] w_a, w_b;
    logic [4:0]  w_sh;
    logic signed [63:0] w_p;

    ddo_mul u_mul (.i_clk(i_clk), .i_a(w_a), .i_b(w_b), .i_shift(w_sh), .o_p(w_p));

    // operand select for the multiplier
    always_comb begin
        w_a = '0; w_b = '0; w_sh = '0;
        unique case (r_st)
            ST_DL: begin
                w_a = {r_lc[31], r_lc - r_llast}; w_a[32] = w_a[31];
                w_b = {9'd0, r_lmm}; w_sh = 5'd8;
            end
            ST_DR: begin
                w_a = {r_rc[31], r_rc - r_rlast}; w_a[32] = w_a[31];
                w_b = {9'd0, r_rmm}; w_sh = 5'd8;
            end
            ST_LRAW: begin w_a = {r_dl[31], r_dl}; w_b = {19'd0, r_rate}; end
            ST_RRAW: begin w_a = {r_dr[31], r_dr}; w_b = {19'd0, r_rate}; end
            ST_LFILT: begin
                w_a = {r_lraw[31], r_lraw} - {r_ls[31], r_ls};
                w_b = {16'd0, r_alpha}; w_sh = 5'd16;
            end
            ST_RFILT: begin
                w_a = {r_rraw[31], r_rraw} - {r_rs[31], r_rs};
                w_b = {16'd0, r_alpha}; w_sh = 5'd16;
            end
            ST_DANG: begin
                w_a = {r_dr[31], r_dr} - {r_dl[31], r_dl};
                w_b = {9'd0, r_iwb}; w_sh = 5'd16;
            end
            ST_XMUL: begin
                w_a = {r_mean[31], r_mean};
                w_b = r_flip ? -{r_cx[31], r_cx} : {r_cx[31], r_cx}; w_sh = 5'd30;
            end
            ST_YMUL: begin
                w_a = {r_mean[31], r_mean};
                w_b = r_flip ? -{r_cy[31], r_cy} : {r_cy[31], r_cy}; w_sh = 5'd30;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE:  if (in_if.valid) n_st = in_if.data.mode ? ST_FOLD : ST_DL;
            ST_DL:    n_st = ST_DR;
            ST_DR:    n_st = ST_LRAW;
            ST_LRAW:  n_st = ST_RRAW;
            ST_RRAW:  n_st = ST_LFILT;
            ST_LFILT: n_st = ST_RFILT;
            ST_RFILT: n_st = ST_DANG;
            ST_DANG:  n_st = ST_HEAD;
            ST_HEAD:  n_st = ST_FOLD;
            ST_FOLD:  n_st = r_setpose ? ST_OUT : ST_MEAN;
            ST_MEAN:  n_st = ST_RED;
            ST_RED:   if (r_it == SW'(4)) n_st = ST_ITER;
            ST_ITER:  if (r_it == SW'(CORDIC_STEPS - 1) || CORDIC_STEPS == 0) n_st = ST_XMUL;
            ST_XMUL:  n_st = ST_YMUL;
            ST_YMUL:  n_st = ST_DONE;
            ST_DONE:  n_st = ST_OUT;
            ST_OUT:   if (out_if.ready) n_st = ST_IDLE;
            default:  n_st = ST_IDLE;
        endcase
    end

    assign in_if.ready  = (r_st == ST_IDLE);
    assign out_if.valid = (r_st == ST_OUT);
    always_comb begin
        out_if.data.pos_x = r_x;
        out_if.data.pos_y = r_y;
        out_if.data.heading = r_h;
        out_if.data.turn_count = r_turns;
        out_if.data.left_speed = r_ls;
        out_if.data.right_speed = r_rs;
    end

    logic signed [33:0] w_sum, w_rm, w_rs, w_ra, w_rt, w_qt;
    logic               w_fl;
    logic signed [31:0] w_xs, w_ys, w_at;
    logic signed [63:0] w_hs;

    always_comb begin
        w_sum = 34'(r_h) + 34'(r_prev) + 34'sd1;
        w_xs = r_cy >>> r_it;
        w_ys = r_cx >>> r_it;
        w_at = 32'(atan_q(5'(r_it)));
        w_hs = 64'(r_h) + w_p;
        // remove 16, 8, 4, 2, then 1 turns, one step per cycle
        w_rm = 34'(TWO_PI_Q) <<< (SW'(4) - r_it);
        w_rs = 34'(r_cz) - w_rm;
        w_ra = 34'(r_cz) + w_rm;
        if (w_rs >= 34'(RED_LO)) w_rt = w_rs;
        else if (w_ra <= 34'(PI_Q)) w_rt = w_ra;
        else w_rt = 34'(r_cz);
        // half-turn shift into the rotation range, results negated later
        w_qt = w_rt;
        w_fl = 1'b0;
        if (w_rt > 34'(HALF_PI_Q)) begin
            w_qt = w_rt - 34'(PI_Q); w_fl = 1'b1;
        end else if (w_rt < -34'(HALF_PI_Q)) begin
            w_qt = w_rt + 34'(PI_Q); w_fl = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_lmm <= '0; r_rmm <= '0; r_iwb <= '0; r_rate <= 14'd100;
            r_alpha <= 17'd25297; r_wrap <= 1'b1;
            r_llast <= '0; r_rlast <= '0; r_prev <= '0; r_x <= '0; r_y <= '0;
            r_h <= '0; r_turns <= '0; r_ls <= '0; r_rs <= '0;
        end else begin
            r_st <= n_st;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_LEFT_MM:  r_lmm <= i_cfg_data;
                    REG_RIGHT_MM: r_rmm <= i_cfg_data;
                    REG_INV_WB:   r_iwb <= i_cfg_data;
                    REG_RATE:     r_rate <= i_cfg_data[13:0];
                    REG_ALPHA:    r_alpha <= i_cfg_data[16:0];
                    REG_WRAP:     r_wrap <= i_cfg_data[0];
                    default: ;
                endcase
            end
            unique case (r_st)
                ST_IDLE: if (in_if.valid) begin
                    r_setpose <= in_if.data.mode;
                    r_lc <= in_if.data.left_count;
                    r_rc <= in_if.data.right_count;
                    if (in_if.data.mode) begin
                        r_x <= in_if.data.pose_x;
                        r_y <= in_if.data.pose_y;
                        r_h <= in_if.data.pose_heading;
                    end
                end
                ST_DR:    r_dl <= sat64(w_p);
                ST_LRAW:  r_dr <= sat64(w_p);
                ST_RRAW:  r_lraw <= sat64(w_p);
                ST_LFILT: r_rraw <= sat64(w_p);
                ST_RFILT: r_ls <= sat64(64'(r_ls) + w_p);
                ST_DANG:  r_rs <= sat64(64'(r_rs) + w_p);
                ST_HEAD:  r_h <= sat64(w_hs);
                ST_FOLD: begin
                    if (r_wrap || r_setpose) begin
                        if (r_h > PI_Q) begin
                            r_h <= r_h - TWO_PI_Q;
                            if (r_turns != 16'sh7fff) r_turns <= r_turns + 16'sd1;
                        end else if (r_h <= -PI_Q) begin
                            r_h <= r_h + TWO_PI_Q;
                            if (r_turns != 16'sh8000) r_turns <= r_turns - 16'sd1;
                        end
                    end
                end
                ST_MEAN: begin
                    r_mean <= 32'((34'(r_dl) + 34'(r_dr) + 34'sd1) >>> 1);
                    r_cz   <= 32'(w_sum >>> 1);
                    r_it   <= '0;
                end
                ST_RED: begin
                    if (r_it == SW'(4)) begin
                        r_cz <= 32'(w_qt);
                        r_flip <= w_fl;
                        r_cx <= CORDIC_GAIN;
                        r_cy <= '0;
                        r_it <= '0;
                    end else begin
                        r_cz <= 32'(w_rt);
                        r_it <= r_it + 1'b1;
                    end
                end
                ST_ITER: begin
                    if (r_cz >= 0) begin
                        r_cx <= r_cx - w_xs; r_cy <= r_cy + w_ys; r_cz <= r_cz - w_at;
                    end else begin
                        r_cx <= r_cx + w_xs; r_cy <= r_cy - w_ys; r_cz <= r_cz + w_at;
                    end
                    r_it <= r_it + 1'b1;
                end
                ST_YMUL: r_x <= sat64(64'(r_x) + w_p);
                ST_DONE: if (!r_setpose) begin
                    r_y <= sat64(64'(r_y) + w_p);
                    r_llast <= r_lc; r_rlast <= r_rc; r_prev <= r_h;
                end
                default: ;
            endcase
        end
    end

    `DDO_ASSERT(a_excl, !(in_if.ready && out_if.valid), "ready and valid overlap")
    `DDO_ASSERT_NEXT(a_out_hold, out_if.valid && !out_if.ready, out_if.valid,
        "result dropped")
    `DDO_ASSERT_NEXT(a_acc, in_if.valid && in_if.ready, !in_if.ready, "ready after accept")
endmodule

// ----- tb/tb_differential_drive_odometry.sv -----
// testbench for the differential-drive odometry block: directed table, then random phases
module tb_differential_drive_odometry;
    import ddo_pkg::*;

    typedef struct {
        t_cmd  cmd;
        bit    typed;
        t_pose want;
    } t_vec_row;

    localparam logic MODE_UPDATE = 1'b0;
    localparam logic MODE_SET    = 1'b1;
    localparam int   NUM_STEPS   = 24;
    localparam int   ATAN_Q[0:31] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2,
        1, 0, 0, 0, 0, 0, 0, 0
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [23:0] i_cfg_data;

    ddo_stream_if #(.T(t_cmd))  cmd_if ();
    ddo_stream_if #(.T(t_pose)) pose_if ();

    differential_drive_odometry #(.CORDIC_STEPS(NUM_STEPS)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .in_if       (cmd_if),
        .out_if      (pose_if)
    );

    // predictor copy of configuration and state
    longint mm_left, mm_right, inv_wb, rate_hz, alpha, wrap_on;
    int     last_l, last_r;
    longint prev_head, x_q, y_q, head_q, turns_q, lspd_q, rspd_q;

    t_pose     pose_q[$];
    int        mismatches;
    bit        idle_en;
    int        hold_reqs;

    function automatic longint rnd_shr(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic void fold_head();
        if (head_q > longint'(PI_Q)) begin
            head_q -= longint'(TWO_PI_Q);
            if (turns_q < 32767) turns_q++;
        end else if (head_q <= -longint'(PI_Q)) begin
            head_q += longint'(TWO_PI_Q);
            if (turns_q > -32768) turns_q--;
        end
    endfunction

    function automatic void rotate(input longint ang, output longint c, output longint s);
        longint r, x, y, nx;
        bit     flip;
        r = ang % longint'(TWO_PI_Q);
        x = longint'(CORDIC_GAIN);
        y = 0;
        flip = 0;
        if (r < 0) r += longint'(TWO_PI_Q);
        if (r > longint'(PI_Q)) r -= longint'(TWO_PI_Q);
        if (r > longint'(HALF_PI_Q)) begin
            r -= longint'(PI_Q);
            flip = 1;
        end else if (r < -longint'(HALF_PI_Q)) begin
            r += longint'(PI_Q);
            flip = 1;
        end
        for (int i = 0; i < NUM_STEPS; i++) begin
            if (r >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                r -= ATAN_Q[i];
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                r += ATAN_Q[i];
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint low_pass(longint old, longint raw);
        return clip32(old + rnd_shr(alpha * (raw - old), 16));
    endfunction

    function automatic t_pose odo_advance(t_cmd c);
        t_pose     p;
        int        ldel, rdel;
        longint    dl, dr, dang, mean, cs, sn;
        if (c.mode == MODE_SET) begin
            x_q = longint'(c.pose_x);
            y_q = longint'(c.pose_y);
            head_q = longint'(c.pose_heading);
            fold_head();
        end else begin
            ldel = c.left_count - last_l;
            rdel = c.right_count - last_r;
            dl = clip32(rnd_shr(longint'(ldel) * mm_left, 8));
            dr = clip32(rnd_shr(longint'(rdel) * mm_right, 8));
            lspd_q = low_pass(lspd_q, clip32(dl * rate_hz));
            rspd_q = low_pass(rspd_q, clip32(dr * rate_hz));
            dang = rnd_shr((dr - dl) * inv_wb, 16);
            head_q = clip32(head_q + dang);
            if (wrap_on != 0) fold_head();
            mean = rnd_shr(dl + dr, 1);
            rotate(rnd_shr(head_q + prev_head, 1), cs, sn);
            x_q = clip32(x_q + rnd_shr(mean * cs, 30));
            y_q = clip32(y_q + rnd_shr(mean * sn, 30));
            last_l = c.left_count;
            last_r = c.right_count;
            prev_head = head_q;
        end
        p.pos_x = x_q[31:0];
        p.pos_y = y_q[31:0];
        p.heading = head_q[31:0];
        p.turn_count = turns_q[15:0];
        p.left_speed = lspd_q[31:0];
        p.right_speed = rspd_q[31:0];
        return p;
    endfunction

    function automatic t_cmd rand_cmd();
        t_cmd c;
        c.mode = ($urandom_range(0, 7) == 0) ? MODE_SET : MODE_UPDATE;
        c.left_count = $urandom;
        c.right_count = $urandom;
        c.pose_x = $urandom;
        c.pose_y = $urandom;
        c.pose_heading = $urandom;
        // mostly small encoder steps, now and then a wild jump
        if ($urandom_range(0, 15) != 0) begin
            c.left_count = last_l + $signed($urandom_range(0, 4000)) - 2000;
            c.right_count = last_r + $signed($urandom_range(0, 4000)) - 2000;
        end
        if ($urandom_range(0, 3) != 0) begin
            c.pose_x = $signed($urandom_range(0, 20000000)) - 10000000;
            c.pose_y = $signed($urandom_range(0, 20000000)) - 10000000;
            c.pose_heading = $signed($urandom_range(0, 420000000)) - 210000000;
        end
        return c;
    endfunction

    task automatic send_cmd(t_cmd c, bit typed, t_pose want);
        t_pose p;
        cmd_if.valid <= 1'b1;
        cmd_if.data <= c;
        do @(posedge i_clk); while (!(cmd_if.valid && cmd_if.ready));
        p = odo_advance(c);
        pose_q.push_back(typed ? want : p);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pose_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_LEFT_MM:  mm_left = longint'(val);
            REG_RIGHT_MM: mm_right = longint'(val);
            REG_INV_WB:   inv_wb = longint'(val);
            REG_RATE:     rate_hz = longint'(val[13:0]);
            REG_ALPHA:    alpha = longint'(val[16:0]);
            REG_WRAP:     wrap_on = longint'(val[0]);
            default: ;
        endcase
    endtask

    task automatic write_all(logic [23:0] l, logic [23:0] r, logic [23:0] w,
                             logic [23:0] rt, logic [23:0] a, logic [23:0] wr);
        write_reg(REG_LEFT_MM, l);
        write_reg(REG_RIGHT_MM, r);
        write_reg(REG_INV_WB, w);
        write_reg(REG_RATE, rt);
        write_reg(REG_ALPHA, a);
        write_reg(REG_WRAP, wr);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #40000000;
        $display("status: fail");
        $finish;
    end

    // result side: random stalls, one long hold on request
    initial begin
        int burst;
        int seen;
        burst = 0;
        seen = 0;
        forever begin
            @(posedge i_clk);
            if (pose_if.valid && pose_if.ready) begin
                if (pose_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result beat %p", pose_if.data);
                end else begin
                    t_pose w;
                    w = pose_q.pop_front();
                    if (pose_if.data !== w) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p got %p", w, pose_if.data);
                    end
                end
            end
            if (hold_reqs != seen) begin
                seen = hold_reqs;
                burst = 300;
            end
            if (burst > 0) begin
                burst--;
                pose_if.ready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(0, 2);
                pose_if.ready <= 1'b0;
            end else begin
                pose_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        t_vec_row  rows[$];
        t_vec_row  row;
        t_pose     zero_pose;
        int        lim;

        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        cmd_if.valid = 1'b0;
        cmd_if.data = '0;
        pose_if.ready = 1'b0;
        mismatches = 0;
        hold_reqs = 0;
        idle_en = 1;
        mm_left = 0; mm_right = 0; inv_wb = 0; rate_hz = 100; alpha = 25297; wrap_on = 1;
        last_l = 0; last_r = 0;
        prev_head = 0; x_q = 0; y_q = 0; head_q = 0; turns_q = 0; lspd_q = 0; rspd_q = 0;
        zero_pose = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table at reset configuration
        row.cmd = '{MODE_UPDATE, 32'sd5, -32'sd7, 32'sd0, 32'sd0, 32'sd0};
        row.typed = 1; row.want = zero_pose; rows.push_back(row);
        row.cmd = '{MODE_SET, 32'sd0, 32'sd0, SAT_MAX, SAT_MIN, 32'sd0};
        row.want = '{SAT_MAX, SAT_MIN, 32'sd0, 16'sd0, 32'sd0, 32'sd0}; rows.push_back(row);
        // just above pi folds down one turn
        row.cmd = '{MODE_SET, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd52707180};
        row.want = '{32'sd0, 32'sd0, -32'sd52707177, 16'sd1, 32'sd0, 32'sd0};
        rows.push_back(row);
        // exactly -pi folds up
        row.cmd = '{MODE_SET, 32'sd0, 32'sd0, 32'sd0, 32'sd0, -32'sd52707179};
        row.want = '{32'sd0, 32'sd0, 32'sd52707178, 16'sd0, 32'sd0, 32'sd0};
        rows.push_back(row);
        row.typed = 0;
        row.cmd = '{MODE_SET, 32'sd0, 32'sd0, SAT_MIN, SAT_MAX, SAT_MAX}; rows.push_back(row);
        row.cmd = '{MODE_SET, 32'sd0, 32'sd0, -32'sd1, 32'sd1, SAT_MIN}; rows.push_back(row);
        row.cmd = '{MODE_SET, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd52707179}; rows.push_back(row);
        row.cmd = '{MODE_UPDATE, SAT_MAX, SAT_MIN, 32'sd0, 32'sd0, 32'sd0}; rows.push_back(row);
        row.cmd = '{MODE_UPDATE, SAT_MIN, SAT_MAX, -32'sd1, -32'sd1, -32'sd1};
        rows.push_back(row);
        row.cmd = '{MODE_UPDATE, -32'sd1, -32'sd1, 32'sd0, 32'sd0, 32'sd0}; rows.push_back(row);
        row.cmd = '{MODE_UPDATE, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}; rows.push_back(row);
        foreach (rows[i]) send_cmd(rows[i].cmd, rows[i].typed, rows[i].want);
        drain();

        // index past the register list is ignored
        write_reg(3'd6, 24'hffffff);
        write_reg(3'd7, 24'h000001);

        for (int ph = 0; ph < 7; ph++) begin
            drain();
            case (ph)
                0: write_all(24'd1677721, 24'd1690000, 24'd55924, 24'd100, 24'd25297, 24'd1);
                1: write_all(24'hffffff, 24'hffffff, 24'hffffff, 24'd10000, 24'd65536, 24'd1);
                2: write_all(24'd0, 24'hffffff, 24'd1, 24'd0, 24'd0, 24'd0);
                3: write_all(24'hffffff, 24'd1, 24'hffffff, 24'h3fff, 24'h1ffff, 24'd0);
                4: write_all(24'd1, 24'd0, 24'd0, 24'd1, 24'd65535, 24'd1);
                default: write_all(24'($urandom), 24'($urandom),
                                   24'($urandom_range(0, 2000000)),
                                   24'($urandom_range(1, 10000)),
                                   24'($urandom_range(0, 65536)),
                                   24'($urandom_range(0, 1)));
            endcase
            if (ph == 6) idle_en = 0;
            lim = (ph == 0 || ph >= 5) ? 360 : 180;
            for (int n = 0; n < lim; n++) begin
                if (ph == 0 && n == 40) hold_reqs++;
                // sender waits for all results once mid-phase
                if (ph == 0 && n == 120) drain();
                send_cmd(rand_cmd(), 0, zero_pose);
            end
        end

        cmd_if.valid <= 1'b0;
        while (pose_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
